// ----- sv/owb_pkg.sv -----
package owb_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_ONE_LOW       = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_SLOT_LENGTH   = 3'd7;

  // Register reset values
  localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd70;
  localparam logic [9:0] RESET_TAIL_DEFAULT    = 10'd410;
  localparam logic [6:0] ONE_LOW_DEFAULT       = 7'd6;
  localparam logic [6:0] ZERO_LOW_DEFAULT      = 7'd60;
  localparam logic [6:0] READ_LOW_DEFAULT      = 7'd6;
  localparam logic [6:0] READ_SAMPLE_DEFAULT   = 7'd9;
  localparam logic [6:0] SLOT_LENGTH_DEFAULT   = 7'd70;

  // Action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_tail_time;
    logic [6:0] one_low_time;
    logic [6:0] zero_low_time;
    logic [6:0] read_low_time;
    logic [6:0] read_sample_delay;
    logic [6:0] slot_length;
  } cfg_t;

  typedef struct packed {
    logic       command_rejected;
    logic [7:0] rx_byte;
    logic       presence;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

  // A timing register written as zero behaves as one
  function automatic logic [9:0] at_least_one10(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [6:0] at_least_one7(input logic [6:0] v);
    return (v == 7'd0) ? 7'd1 : v;
  endfunction

endpackage

// ----- sv/owb_cfg.sv -----
module owb_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [9:0]       cfg_data,
  output owb_pkg::cfg_t    cfg
);

  assign cfg_ready = 1'b1;

  // Timing registers, written one word at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time     <= owb_pkg::RESET_LOW_DEFAULT;
      cfg.presence_wait_time <= owb_pkg::PRESENCE_WAIT_DEFAULT;
      cfg.reset_tail_time    <= owb_pkg::RESET_TAIL_DEFAULT;
      cfg.one_low_time       <= owb_pkg::ONE_LOW_DEFAULT;
      cfg.zero_low_time      <= owb_pkg::ZERO_LOW_DEFAULT;
      cfg.read_low_time      <= owb_pkg::READ_LOW_DEFAULT;
      cfg.read_sample_delay  <= owb_pkg::READ_SAMPLE_DEFAULT;
      cfg.slot_length        <= owb_pkg::SLOT_LENGTH_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        owb_pkg::REG_RESET_LOW:     cfg.reset_low_time     <= cfg_data;
        owb_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_time <= cfg_data;
        owb_pkg::REG_RESET_TAIL:    cfg.reset_tail_time    <= cfg_data;
        owb_pkg::REG_ONE_LOW:       cfg.one_low_time       <= cfg_data[6:0];
        owb_pkg::REG_ZERO_LOW:      cfg.zero_low_time      <= cfg_data[6:0];
        owb_pkg::REG_READ_LOW:      cfg.read_low_time      <= cfg_data[6:0];
        owb_pkg::REG_READ_SAMPLE:   cfg.read_sample_delay  <= cfg_data[6:0];
        owb_pkg::REG_SLOT_LENGTH:   cfg.slot_length        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/owb_engine.sv -----
module owb_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        action,
  input  logic [7:0]        tx_byte,
  input  logic              line_level,
  input  owb_pkg::cfg_t     cfg,
  output owb_pkg::result_t  res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RLOW  = 3'd1;
  localparam logic [2:0] PH_RWAIT = 3'd2;
  localparam logic [2:0] PH_RTAIL = 3'd3;
  localparam logic [2:0] PH_SLOT  = 3'd4;

  logic [2:0] phase, phase_next;
  logic [9:0] tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       presence_flag, presence_flag_next;
  logic       read_mode, read_mode_next;

  // Next state for one tick: command start, then the tick itself
  always_comb begin
    logic [9:0] tc_inc;
    logic [6:0] low;
    logic [7:0] samp;
    logic [7:0] slot_end;
    logic       drive;
    logic       done;
    logic       rejected;

    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    presence_flag_next = presence_flag;
    read_mode_next     = read_mode;
    drive              = 1'b0;
    done               = 1'b0;
    rejected           = 1'b0;
    low                = 7'd0;
    samp               = 8'd0;
    slot_end           = 8'd0;

    // command start, rejected while an operation runs
    if (action != owb_pkg::ACT_TICK) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        tick_count_next = 10'd0;
        bit_index_next  = 3'd0;
        unique case (action)
          owb_pkg::ACT_RESET: phase_next = PH_RLOW;
          owb_pkg::ACT_WRITE: begin
            phase_next     = PH_SLOT;
            read_mode_next = 1'b0;
            shift_reg_next = tx_byte;
          end
          default: begin
            phase_next     = PH_SLOT;
            read_mode_next = 1'b1;
            shift_reg_next = 8'd0;
          end
        endcase
      end
    end

    tc_inc = tick_count_next + 10'd1;

    // the tick
    unique case (phase_next)
      PH_RLOW: begin
        drive           = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= owb_pkg::at_least_one10(cfg.reset_low_time)) begin
          phase_next      = PH_RWAIT;
          tick_count_next = 10'd0;
        end
      end
      PH_RWAIT: begin
        tick_count_next = tc_inc;
        if (tc_inc >= owb_pkg::at_least_one10(cfg.presence_wait_time)) begin
          phase_next      = PH_RTAIL;
          tick_count_next = 10'd0;
        end
      end
      PH_RTAIL: begin
        if (tick_count_next == 10'd0) presence_flag_next = !line_level;
        tick_count_next = tc_inc;
        if (tc_inc >= owb_pkg::at_least_one10(cfg.reset_tail_time)) begin
          phase_next      = PH_IDLE;
          tick_count_next = 10'd0;
          done            = 1'b1;
        end
      end
      PH_SLOT: begin
        if (read_mode_next) low = owb_pkg::at_least_one7(cfg.read_low_time);
        else if (shift_reg_next[0]) low = owb_pkg::at_least_one7(cfg.one_low_time);
        else low = owb_pkg::at_least_one7(cfg.zero_low_time);
        drive    = (tick_count_next < {3'd0, low});
        slot_end = {1'b0, low} + 8'd1;
        if (read_mode_next) begin
          samp = {1'b0, low} + {1'b0, owb_pkg::at_least_one7(cfg.read_sample_delay)};
          if (tick_count_next == {2'd0, samp})
            shift_reg_next = {line_level, shift_reg_next[7:1]};
          slot_end = samp + 8'd1;
        end
        if (slot_end < {1'b0, cfg.slot_length}) slot_end = {1'b0, cfg.slot_length};
        tick_count_next = tc_inc;
        if (tc_inc >= {2'd0, slot_end}) begin
          tick_count_next = 10'd0;
          if (!read_mode_next) shift_reg_next = {1'b0, shift_reg_next[7:1]};
          if (bit_index_next == 3'd7) begin
            bit_index_next = 3'd0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 10'd0;
      end
    endcase

    res.drive_low        = drive;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done;
    res.presence         = presence_flag_next;
    res.rx_byte          = read_mode_next ? shift_reg_next : 8'd0;
    res.command_rejected = rejected;
  end

  // State registers advance once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= 10'd0;
      bit_index     <= 3'd0;
      shift_reg     <= 8'd0;
      presence_flag <= 1'b0;
      read_mode     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      presence_flag <= presence_flag_next;
      read_mode     <= read_mode_next;
    end
  end

  // a finishing operation always leaves the master idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  // bit position only moves inside a slot sequence
  a_bit_in_slot: assert property (@(posedge clk) disable iff (rst)
    bit_index != 3'd0 |-> phase == PH_SLOT)
    else $error("bit index set outside a slot");

  // going idle leaves the tick counter cleared
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    step && !res.busy_res |=> tick_count == 10'd0)
    else $error("tick counter not cleared when idle");

endmodule

// ----- sv/one_wire_bus_master.sv -----
// 1-Wire bus master, one input word per one-microsecond tick. Every accepted
// word yields exactly one result word. The block takes one word per clock
// cycle while the result stream is not stalled. An input word is held in the
// input register; the tick logic then feeds the result register.
// The rate is set by the single engine state update per tick (phase, tick
// counter, bit index, shift register). Commands (reset pulse, byte write,
// byte read) arriving during an operation are ignored and flagged. The user
// must write timing registers through the cfg port while idle (not enforced).
module one_wire_bus_master (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] line_level, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                 // [3] presence, [11:4] rx_byte,
                                 // [12] command_rejected, rest zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  owb_pkg::cfg_t    cfg;
  owb_pkg::result_t res;

  logic       in_valid;
  logic [1:0] in_action;
  logic [7:0] in_tx_byte;
  logic       in_line;
  logic       advance;

  owb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input word moves to the result register when that one is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action  <= s_tuser;
      in_tx_byte <= s_tdata[7:0];
      in_line    <= s_tdata[8];
    end
  end

  owb_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .action     (in_action),
    .tx_byte    (in_tx_byte),
    .line_level (in_line),
    .cfg        (cfg),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'd0, res.command_rejected, res.rx_byte, res.presence,
                  res.done_res, res.busy_res, res.drive_low};
    end
  end

endmodule
